[hw/rtl/sleep_timer_queue_top_defines.svh]
// Assertion macros shared by the sleep timer queue RTL.
`ifndef SLEEP_TIMER_QUEUE_TOP_DEFINES_SVH
`define SLEEP_TIMER_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/stq_pkg.sv]
// Shared types and constants of the sleep timer queue.
`default_nettype none
package stq_pkg;

	localparam int ID_W        = 31;
	localparam int DUR_W       = 31;
	localparam int TIME_W      = 32;
	localparam int OVER_W      = 31;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		ST_WOKEN     = 3'd0,
		ST_ACCEPTED  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_NONE_DUE  = 3'd4
	} stq_status_t;

	typedef enum logic {
		CMD_HEARTBEAT = 1'b0,
		CMD_SLEEP     = 1'b1
	} stq_command_t;

	// Controller to datapath.
	typedef struct packed {
		logic        scan_start;
		logic        commit;
		logic        take;
		logic        emit_req;
		stq_status_t emit_status;
		logic        emit_woken;
		logic        emit_last;
	} stq_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_sleep;
		logic scan_done;
		logic dup_found;
		logic free_found;
		logic best_found;
		logic emit_done;
	} stq_stat_t;

endpackage
`default_nettype wire

[hw/rtl/stq_in_if.sv]
// Request channel: command beat into the queue.
`default_nettype none
interface stq_in_if import stq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               command;
	logic [ID_W-1:0]    object_id;
	logic [DUR_W-1:0]   duration;
	logic [TIME_W-1:0]  new_time;

	modport source (output valid, command, object_id, duration, new_time, input ready);
	modport sink   (input valid, command, object_id, duration, new_time, output ready);
endinterface
`default_nettype wire

[hw/rtl/stq_out_if.sv]
// Response channel: result beat out of the queue.
`default_nettype none
interface stq_out_if import stq_pkg::*; ();
	logic              valid;
	logic              ready;
	stq_status_t       status;
	logic [ID_W-1:0]   woken_id;
	logic [OVER_W-1:0] overslept;
	logic              last;

	modport source (output valid, status, woken_id, overslept, last, input ready);
	modport sink   (input valid, status, woken_id, overslept, last, output ready);
endinterface
`default_nettype wire

[hw/rtl/stq_ctrl.sv]
// Sequencing state machine of the sleep timer queue.
`default_nettype none
module stq_ctrl import stq_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_fire,
	input  wire stq_stat_t stat,
	output logic           in_ready,
	output stq_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_NEXT,
		S_EMIT
	} state_t;

	state_t           state_q;
	logic             ready_q;
	logic [CNT_W-1:0] woken_q;
	logic             then_take_q;
	stq_cmd_t         cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ready_q     <= 1'b1;
			woken_q     <= '0;
			then_take_q <= 1'b0;
			cmd_q       <= '0;
		end else begin
			// single-cycle pulses
			cmd_q.scan_start <= 1'b0;
			cmd_q.commit     <= 1'b0;
			cmd_q.take       <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						ready_q <= 1'b0;
						woken_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (stat.scan_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (stat.is_sleep) begin
						cmd_q.emit_req   <= 1'b1;
						cmd_q.emit_woken <= 1'b0;
						cmd_q.emit_last  <= 1'b1;
						then_take_q      <= 1'b0;
						if (stat.dup_found) begin
							cmd_q.emit_status <= ST_DUPLICATE;
						end else if (stat.free_found) begin
							cmd_q.emit_status <= ST_ACCEPTED;
							cmd_q.commit      <= 1'b1;
						end else begin
							cmd_q.emit_status <= ST_FULL;
						end
						state_q <= S_EMIT;
					end else if (woken_q == '0) begin
						if (stat.best_found) begin
							cmd_q.take <= 1'b1;
							woken_q    <= woken_q + CNT_W'(1);
							state_q    <= S_NEXT;
						end else begin
							cmd_q.emit_req    <= 1'b1;
							cmd_q.emit_status <= ST_NONE_DUE;
							cmd_q.emit_woken  <= 1'b0;
							cmd_q.emit_last   <= 1'b1;
							then_take_q       <= 1'b0;
							state_q           <= S_EMIT;
						end
					end else begin
						// flush the held entry; it is last when nothing more is due
						cmd_q.emit_req    <= 1'b1;
						cmd_q.emit_status <= ST_WOKEN;
						cmd_q.emit_woken  <= 1'b1;
						cmd_q.emit_last   <= !stat.best_found;
						then_take_q       <= stat.best_found;
						state_q           <= S_EMIT;
					end
				end
				S_NEXT: begin
					if (woken_q == CNT_W'(MAX_RESULTS)) begin
						cmd_q.emit_req    <= 1'b1;
						cmd_q.emit_status <= ST_WOKEN;
						cmd_q.emit_woken  <= 1'b1;
						cmd_q.emit_last   <= 1'b1;
						then_take_q       <= 1'b0;
						state_q           <= S_EMIT;
					end else begin
						cmd_q.scan_start <= 1'b1;
						state_q          <= S_SCAN;
					end
				end
				S_EMIT: begin
					if (stat.emit_done) begin
						cmd_q.emit_req <= 1'b0;
						if (then_take_q) begin
							cmd_q.take <= 1'b1;
							woken_q    <= woken_q + CNT_W'(1);
							state_q    <= S_NEXT;
						end else begin
							ready_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = ready_q;
	assign cmd      = cmd_q;

endmodule
`default_nettype wire

[hw/rtl/stq_dp.sv]
// Slot store, scan pipeline and result register of the sleep timer queue.
`default_nettype none
module stq_dp import stq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_fire,
	input  wire logic               command,
	input  wire logic [ID_W-1:0]    object_id,
	input  wire logic [DUR_W-1:0]   duration,
	input  wire logic [TIME_W-1:0]  new_time,
	input  wire stq_cmd_t           cmd,
	output stq_stat_t               stat,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output stq_status_t             out_status,
	output logic [ID_W-1:0]         out_woken_id,
	output logic [OVER_W-1:0]       out_overslept,
	output logic                    out_last
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	// slot store
	logic [ID_W-1:0]        id_mem   [QUEUE_DEPTH];
	logic [TIME_W-1:0]      wake_mem [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_q;

	// request and time
	logic [TIME_W-1:0] cur_time_q;
	logic              is_sleep_q;
	logic [ID_W-1:0]   req_id_q;
	logic [DUR_W-1:0]  req_dur_q;

	// scan address stage and compare stage
	logic              scan_act_q;
	logic [IDX_W-1:0]  addr_q;
	logic              cmp_v_s1;
	logic              last_s1;
	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [ID_W-1:0]   rd_id_s1;
	logic [TIME_W-1:0] rd_wake_s1;
	logic              done_q;

	// scan results
	logic              dup_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              best_found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [ID_W-1:0]   best_id_q;
	logic [OVER_W-1:0] best_diff_q;

	// entry held for the next result beat
	logic [ID_W-1:0]   pend_id_q;
	logic [OVER_W-1:0] pend_over_q;

	logic              out_valid_q;
	logic              scan_go;
	logic              emit_fire;
	logic [TIME_W-1:0] diff;
	logic              due;
	logic              better;

	assign scan_go   = in_fire || cmd.scan_start;
	assign emit_fire = cmd.emit_req && (!out_valid_q || out_ready);
	assign diff      = cur_time_q - rd_wake_s1;
	assign due       = valid_s1 && !diff[TIME_W-1];
	assign better    = due && (!best_found_q || (diff[OVER_W-1:0] > best_diff_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			cur_time_q   <= '0;
			is_sleep_q   <= 1'b0;
			scan_act_q   <= 1'b0;
			addr_q       <= '0;
			cmp_v_s1     <= 1'b0;
			last_s1      <= 1'b0;
			done_q       <= 1'b0;
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				is_sleep_q <= (command == CMD_SLEEP);
				if (command == CMD_HEARTBEAT) begin
					cur_time_q <= new_time;
				end
			end

			// walk the slots, one read a cycle
			if (scan_go) begin
				scan_act_q <= 1'b1;
				addr_q     <= '0;
			end else if (scan_act_q) begin
				if (addr_q == IDX_W'(QUEUE_DEPTH - 1)) begin
					scan_act_q <= 1'b0;
				end else begin
					addr_q <= addr_q + IDX_W'(1);
				end
			end
			cmp_v_s1 <= scan_act_q && !scan_go;
			last_s1  <= scan_act_q && (addr_q == IDX_W'(QUEUE_DEPTH - 1));
			done_q   <= cmp_v_s1 && last_s1;

			if (scan_go) begin
				dup_q        <= 1'b0;
				free_found_q <= 1'b0;
				best_found_q <= 1'b0;
			end else if (cmp_v_s1) begin
				if (valid_s1 && (rd_id_s1 == req_id_q)) begin
					dup_q <= 1'b1;
				end
				if (!valid_s1) begin
					free_found_q <= 1'b1;
				end
				if (better) begin
					best_found_q <= 1'b1;
				end
			end

			if (cmd.commit) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (cmd.take) begin
				valid_q[best_idx_q] <= 1'b0;
			end

			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and memory, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_id_q  <= object_id;
			req_dur_q <= duration;
		end
		if (scan_act_q) begin
			rd_id_s1   <= id_mem[addr_q];
			rd_wake_s1 <= wake_mem[addr_q];
			valid_s1   <= valid_q[addr_q];
			idx_s1     <= addr_q;
		end
		if (cmp_v_s1 && !scan_go) begin
			if (!valid_s1 && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (better) begin
				best_idx_q  <= idx_s1;
				best_id_q   <= rd_id_s1;
				best_diff_q <= diff[OVER_W-1:0];
			end
		end
		if (cmd.commit) begin
			id_mem[free_idx_q]   <= req_id_q;
			wake_mem[free_idx_q] <= cur_time_q + TIME_W'(req_dur_q);
		end
		if (cmd.take) begin
			pend_id_q   <= best_id_q;
			pend_over_q <= best_diff_q;
		end
		if (emit_fire) begin
			out_status    <= cmd.emit_status;
			out_woken_id  <= cmd.emit_woken ? pend_id_q : '0;
			out_overslept <= cmd.emit_woken ? pend_over_q : '0;
			out_last      <= cmd.emit_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign stat.is_sleep   = is_sleep_q;
	assign stat.scan_done  = done_q;
	assign stat.dup_found  = dup_q;
	assign stat.free_found = free_found_q;
	assign stat.best_found = best_found_q;
	assign stat.emit_done  = emit_fire;

endmodule
`default_nettype wire

[hw/rtl/sleep_timer_queue_top.sv]
// Sleep timer queue: top level joining the controller and the datapath.
// Timing: a sleep request, or a heartbeat with nothing due, shows its beat after one scan of
// all QUEUE_DEPTH slots (one slot read a cycle). A heartbeat waking entries shows its first beat
// after two scans and each further one after one more scan, but the sixteenth of a capped burst
// follows the fifteenth with no scan between. Each beat also waits while rsp.ready is low.
// Throughput: one request in flight, next taken once the last beat is registered; reset clears
// control, valid bits and time.
`default_nettype none
`include "sleep_timer_queue_top_defines.svh"
module sleep_timer_queue_top import stq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	stq_in_if.sink    req,
	stq_out_if.source rsp
);

	stq_cmd_t  cmd;
	stq_stat_t stat;
	logic      in_ready;
	logic      in_fire;

	// a request beat lands only when the controller is idle
	assign req.ready = in_ready;
	assign in_fire   = req.valid && in_ready;

	// controller: orders scans, slot commits, wake takes and result beats
	stq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// datapath: slot store, scan compare pipeline and the result register
	stq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.command       (req.command),
		.object_id     (req.object_id),
		.duration      (req.duration),
		.new_time      (req.new_time),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (rsp.ready),
		.out_valid     (rsp.valid),
		.out_status    (rsp.status),
		.out_woken_id  (rsp.woken_id),
		.out_overslept (rsp.overslept),
		.out_last      (rsp.last)
	);

	// idle controller must have no work queued for the datapath
	`STQ_ASSERT_NOW(a_idle_quiet, clk, arst_n, in_ready, !cmd.emit_req && !cmd.take && !cmd.commit, "request taken while work pending")
	// a slot is never filled and freed in the same cycle
	`STQ_ASSERT_NOW(a_commit_take, clk, arst_n, 1'b1, !(cmd.commit && cmd.take), "commit and take together")
	// each result is loaded exactly once
	`STQ_ASSERT_NEXT(a_single_emit, clk, arst_n, stat.emit_done, !stat.emit_done, "result loaded twice")
	// non-wake results end the response and carry no id
	`STQ_ASSERT_NOW(a_plain_last, clk, arst_n, rsp.valid && (rsp.status != ST_WOKEN), rsp.last && (rsp.woken_id == '0), "non-wake result not final")

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench of the sleep timer queue: random and directed commands, scoreboard.
`timescale 1ns / 1ps
module tb_top;
	import stq_pkg::*;

	localparam int QUEUE_DEPTH  = 16;
	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_ITEMS = 300;
	localparam int STALL_CYCLES = 400;
	localparam int STALL_AT     = 40;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		stq_command_t      command;
		logic [ID_W-1:0]   object_id;
		logic [DUR_W-1:0]  duration;
		logic [TIME_W-1:0] new_time;
	} cmd_beat_t;

	typedef struct {
		stq_status_t       status;
		logic [ID_W-1:0]   woken_id;
		logic [OVER_W-1:0] overslept;
		logic              last;
	} rsp_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	stq_in_if  req_if ();
	stq_out_if rsp_if ();

	sleep_timer_queue_top #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Commands still to be offered, and the result beats the timer model says must come out.
	cmd_beat_t cmd_backlog[$];
	rsp_beat_t due_results_q[$];

	// Shadow copy of the timer queue: current tick count and the slot store.
	logic [TIME_W-1:0] clock_now;
	logic              slot_busy [QUEUE_DEPTH];
	logic [ID_W-1:0]   slot_obj  [QUEUE_DEPTH];
	logic [TIME_W-1:0] slot_due  [QUEUE_DEPTH];

	// Tick count the stimulus generator last handed out, so heartbeats move forward mostly.
	logic [TIME_W-1:0] gen_now;

	int total_items = 0;
	int beats_taken = 0;
	int fault_cnt   = 0;
	int cycle_cnt   = 0;
	int stall_left;
	bit stall_armed;

	function automatic rsp_beat_t result_beat(stq_status_t st, logic [ID_W-1:0] id,
			logic [OVER_W-1:0] over, logic lst);
		rsp_beat_t r;
		r.status    = st;
		r.woken_id  = id;
		r.overslept = over;
		r.last      = lst;
		return r;
	endfunction

	// Apply one accepted command to the shadow queue and queue up the beats it must produce.
	task automatic model_timer_cmd(input cmd_beat_t c);
		int                free_slot;
		int                best;
		int                n;
		bit                dup;
		logic [TIME_W-1:0] diff;
		logic [TIME_W-1:0] best_diff;
		free_slot = -1;
		dup       = 1'b0;
		n         = 0;
		if (c.command == CMD_SLEEP) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (slot_busy[i]) begin
					if (slot_obj[i] == c.object_id)
						dup = 1'b1;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (dup) begin
				due_results_q.push_back(result_beat(ST_DUPLICATE, '0, '0, 1'b1));
			end else if (free_slot < 0) begin
				due_results_q.push_back(result_beat(ST_FULL, '0, '0, 1'b1));
			end else begin
				slot_busy[free_slot] = 1'b1;
				slot_obj[free_slot]  = c.object_id;
				slot_due[free_slot]  = clock_now + TIME_W'(c.duration);
				due_results_q.push_back(result_beat(ST_ACCEPTED, '0, '0, 1'b1));
			end
		end else begin
			clock_now = c.new_time;
			// Pick the most overslept due slot each round; a strict compare keeps the lower
			// slot on a tie. A negative signed difference means not due yet.
			while (n < MAX_RESULTS) begin
				best      = -1;
				best_diff = '0;
				for (int i = 0; i < QUEUE_DEPTH; i++) begin
					diff = clock_now - slot_due[i];
					if (slot_busy[i] && !diff[TIME_W-1] && (best < 0 || diff > best_diff)) begin
						best      = i;
						best_diff = diff;
					end
				end
				if (best < 0)
					break;
				slot_busy[best] = 1'b0;
				due_results_q.push_back(result_beat(ST_WOKEN, slot_obj[best],
					best_diff[OVER_W-1:0], 1'b0));
				n++;
			end
			if (n == 0)
				due_results_q.push_back(result_beat(ST_NONE_DUE, '0, '0, 1'b1));
			else
				due_results_q[due_results_q.size() - 1].last = 1'b1;
		end
	endtask

	// Fields a command does not use get random filler so that every bit gets exercised.
	task automatic queue_sleep(input logic [ID_W-1:0] id, input logic [DUR_W-1:0] dur);
		cmd_beat_t c;
		c.command   = CMD_SLEEP;
		c.object_id = id;
		c.duration  = dur;
		c.new_time  = TIME_W'($urandom);
		cmd_backlog.push_back(c);
	endtask

	task automatic queue_beat(input logic [TIME_W-1:0] t);
		cmd_beat_t c;
		c.command   = CMD_HEARTBEAT;
		c.object_id = ID_W'($urandom);
		c.duration  = DUR_W'($urandom);
		c.new_time  = t;
		gen_now     = t;
		cmd_backlog.push_back(c);
	endtask

	// Idle schedule: sender light and receiver heavy, then swapped, then no idling at all.
	function automatic int run_phase(int taken);
		if (total_items == 0)
			return 0;
		return taken * 3 / total_items;
	endfunction

	function automatic int send_idle_pct(int ph);
		return (ph == 0) ? 37 : (ph == 1) ? 65 : 0;
	endfunction

	function automatic int recv_idle_pct(int ph);
		return (ph == 0) ? 65 : (ph == 1) ? 37 : 0;
	endfunction

	// Request driver: pop the head on a taken beat, then offer the next one or idle.
	// Hold the payload steady while a beat waits for ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid     <= 1'b0;
			req_if.command   <= CMD_HEARTBEAT;
			req_if.object_id <= '0;
			req_if.duration  <= '0;
			req_if.new_time  <= '0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				model_timer_cmd(cmd_backlog[0]);
				void'(cmd_backlog.pop_front());
				beats_taken <= beats_taken + 1;
			end
			if (!req_if.valid || req_if.ready) begin
				if (cmd_backlog.size() != 0 &&
						$urandom_range(99) >= send_idle_pct(run_phase(beats_taken))) begin
					req_if.valid     <= 1'b1;
					req_if.command   <= cmd_backlog[0].command;
					req_if.object_id <= cmd_backlog[0].object_id;
					req_if.duration  <= cmd_backlog[0].duration;
					req_if.new_time  <= cmd_backlog[0].new_time;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, armed once early in the run. The sender keeps offering, so
	// the block backs up and must drop ready on its request side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left  <= 0;
			stall_armed <= 1'b1;
		end else if (stall_armed && beats_taken >= STALL_AT) begin
			stall_left  <= STALL_CYCLES;
			stall_armed <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// Compare one taken result beat against the oldest expectation.
	task automatic check_result_beat();
		rsp_beat_t want;
		if (due_results_q.size() == 0) begin
			fault_cnt++;
			if (fault_cnt <= REPORT_MAX)
				$display("%0t: result beat with nothing expected: status %0d id %h over %h last %b",
					$realtime, rsp_if.status, rsp_if.woken_id, rsp_if.overslept, rsp_if.last);
		end else begin
			want = due_results_q.pop_front();
			if (rsp_if.status !== want.status || rsp_if.woken_id !== want.woken_id ||
					rsp_if.overslept !== want.overslept || rsp_if.last !== want.last) begin
				fault_cnt++;
				if (fault_cnt <= REPORT_MAX)
					$display("%0t: mismatch: expected status %0d id %h over %h last %b, got status %0d id %h over %h last %b",
						$realtime, want.status, want.woken_id, want.overslept, want.last,
						rsp_if.status, rsp_if.woken_id, rsp_if.overslept, rsp_if.last);
			end
		end
	endtask

	// Result monitor: check on each taken beat, then pick the next ready value.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready)
				check_result_beat();
			rsp_if.ready <= (stall_left == 0) &&
				($urandom_range(99) >= recv_idle_pct(run_phase(beats_taken)));
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("** sleep_timer_queue_top: FAILED **");
			$finish;
		end
	end

	initial begin : main
		int                r;
		logic [ID_W-1:0]   id;
		logic [DUR_W-1:0]  dur;
		logic [TIME_W-1:0] t;

		clock_now = '0;
		gen_now   = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			slot_busy[i] = 1'b0;
			slot_obj[i]  = '0;
			slot_due[i]  = '0;
		end

		// Directed part.
		queue_beat('0);                          // empty queue: nothing due
		queue_sleep('0, '0);                     // zero duration must not wake on the sleep itself
		queue_sleep('0, DUR_W'(7));              // same id again: duplicate
		queue_beat('0);                          // now wake it, overslept zero
		queue_sleep('1, '1);                     // largest id and duration
		queue_beat('1);                          // wake time far behind in raw value: wrapped, not due
		// Fill the remaining slots; pairs share a duration so the wakeup has ties.
		for (int k = 0; k < QUEUE_DEPTH - 1; k++)
			queue_sleep(ID_W'(32'h100 + k), DUR_W'(k / 2));
		queue_sleep(ID_W'(32'h5555_5555), DUR_W'(3));   // every slot taken: full
		queue_beat(TIME_W'(32'h13));             // tick count wraps; wakes all but the largest id
		queue_beat(TIME_W'(32'hFFFF_FFFE));      // largest overslept amount

		// Random part: mostly coherent traffic on a small id pool, some bursts that fill the
		// queue, some heartbeats that jump anywhere, some fully random commands.
		while (cmd_backlog.size() < 24 + RANDOM_ITEMS) begin
			r = $urandom_range(99);
			if (r < 6) begin
				if ($urandom_range(1) == 0)
					queue_beat(TIME_W'($urandom));
				else
					queue_sleep(ID_W'($urandom), DUR_W'($urandom));
			end else if (r < 9) begin
				for (int k = 0; k < QUEUE_DEPTH + 1; k++)
					queue_sleep(ID_W'(2000 + $urandom_range(40)), DUR_W'($urandom_range(60)));
				queue_beat(gen_now + TIME_W'($urandom_range(80)));
			end else if (r < 58) begin
				id  = ($urandom_range(3) == 0) ? ID_W'($urandom) : ID_W'(1000 + $urandom_range(23));
				dur = ($urandom_range(9) == 0) ? DUR_W'($urandom) : DUR_W'($urandom_range(400));
				queue_sleep(id, dur);
			end else begin
				t = ($urandom_range(19) == 0) ? TIME_W'($urandom)
					: gen_now + TIME_W'($urandom_range(150));
				queue_beat(t);
			end
		end
		total_items = cmd_backlog.size();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all commands taken, all expected beats seen, then a quiet tail.
		while (cmd_backlog.size() != 0 || req_if.valid)
			@(posedge clk);
		while (due_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		fault_cnt += due_results_q.size();

		if (fault_cnt == 0)
			$display("** sleep_timer_queue_top: PASSED **");
		else
			$display("** sleep_timer_queue_top: FAILED **");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/stq_pkg.sv
hw/rtl/stq_in_if.sv
hw/rtl/stq_out_if.sv
hw/rtl/stq_ctrl.sv
hw/rtl/stq_dp.sv
hw/rtl/sleep_timer_queue_top.sv
tb/tb_top.sv
